@@ hdl/sdl_pkg.sv @@
// Shared types and codes for the sorted delete-list row filter.
`default_nettype none
package sdl_pkg;

  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;
  localparam int FIELD_W  = 48;
  localparam int POS_W    = 11;
  localparam int TOTAL_W  = 12;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_FILTER = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ROWS_EN = 2'd0,
    CFG_MAX_ROWS    = 2'd1,
    CFG_SNAP_EN     = 2'd2,
    CFG_SNAP_LIMIT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_SRCH,
    S_SRCH_CMP,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic busy;
    logic accept;
    logic run_cmd;
    logic in_srch;
    logic srch_cmp;
    logic srch_end;
    logic eval;
  } ctrl_t;

endpackage
`default_nettype wire

@@ hdl/sdl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module sdl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/sdl_ctrl.sv @@
// Sequencer for commands, the lower-bound search and row evaluation.
`default_nettype none
module sdl_ctrl
  import sdl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [REQ_W-1:0] req_type,
  input  wire logic             first_of_batch,
  input  wire logic             search_done,
  output ctrl_t                 ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_FILTER) begin
            state_nxt = first_of_batch ? S_SRCH : S_EVAL;
          end else begin
            state_nxt = S_CMD;
          end
        end
      end
      S_CMD:      state_nxt = S_IDLE;
      S_SRCH:     state_nxt = search_done ? S_EVAL : S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = S_SRCH;
      S_EVAL:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE:     ctl.accept = start;
      S_CMD: begin
        ctl.busy    = 1'b1;
        ctl.run_cmd = 1'b1;
      end
      S_SRCH: begin
        ctl.busy     = 1'b1;
        ctl.in_srch  = 1'b1;
        ctl.srch_end = search_done;
      end
      S_SRCH_CMP: begin
        ctl.busy     = 1'b1;
        ctl.srch_cmp = 1'b1;
      end
      S_EVAL: begin
        ctl.busy = 1'b1;
        ctl.eval = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/sorted_delete_list_row_filter.sv @@
// Top level of the sorted delete-list row filter: registers, list RAMs and datapath.
//
// Channel   Handshake              Ports
// input     start high, busy low   in_req_type, in_row_id, in_snapshot_id, in_has_snapshot,
//                                  in_first_of_batch, in_last_of_batch
// result    out_valid, one cycle   out_status, out_keep, out_kept_position, out_row_offset,
//                                  out_kept_total, out_last
// config    cfg_we                 cfg_addr, cfg_wdata
//
// Clear, append and unused codes run in S_CMD; filter rows inside a batch run in S_EVAL.
// A filter word with first_of_batch first runs the search in S_SRCH and S_SRCH_CMP
// for each probe, up to ceil(log2(LIST_DEPTH + 1)) probes, one read of the list RAM per probe.
// The result word appears the cycle after the last work cycle, for one cycle only;
// the receiver cannot stall it, and busy holds off the next input until that cycle.
// Synchronous active-low reset empties the list and clears all counters; the RAMs
// need no clearing pass.
`default_nettype none
module sorted_delete_list_row_filter
  import sdl_pkg::*;
#(
  parameter int LIST_DEPTH = 4096,
  parameter int BATCH_ROWS = 2048,
  parameter int ROW_BITS   = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [FIELD_W-1:0]   in_row_id,
  input  wire logic [FIELD_W-1:0]   in_snapshot_id,
  input  wire logic                 in_has_snapshot,
  input  wire logic                 in_first_of_batch,
  input  wire logic                 in_last_of_batch,
  output logic                      out_valid,
  output logic [STAT_W-1:0]         out_status,
  output logic                      out_keep,
  output logic [POS_W-1:0]          out_kept_position,
  output logic [POS_W-1:0]          out_row_offset,
  output logic [TOTAL_W-1:0]        out_kept_total,
  output logic                      out_last,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [FIELD_W-1:0]   cfg_wdata
);

  localparam int AW    = $clog2(LIST_DEPTH);
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int BW    = $clog2(BATCH_ROWS + 1);
  localparam int CMP_W = (ROW_BITS > FIELD_W) ? ROW_BITS : FIELD_W;

  ctrl_t ctl;

  logic               max_rows_en_r;
  logic [FIELD_W-1:0] max_rows_r;
  logic               snap_en_r;
  logic [FIELD_W-1:0] snap_limit_r;

  logic [REQ_W-1:0]    req_r;
  logic [ROW_BITS-1:0] in_row_r;
  logic [FIELD_W-1:0]  in_snap_r;
  logic                in_has_r;
  logic                in_last_r;

  logic [CW-1:0]       count_r;
  logic                tags_r;
  logic [ROW_BITS-1:0] last_row_r;
  logic [ROW_BITS-1:0] batch_start_r;
  logic [BW-1:0]       offset_r;
  logic [BW-1:0]       kept_r;
  logic [CW-1:0]       ptr_r;
  logic [CW-1:0]       lo_r;
  logic [CW-1:0]       hi_r;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic                out_keep_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [POS_W-1:0]    out_offset_r;
  logic [TOTAL_W-1:0]  out_total_r;
  logic                out_last_r;

  logic [CW-1:0]       mid;
  logic                search_done;
  logic [AW-1:0]       rd_addr;
  logic [ROW_BITS-1:0] rd_row;
  logic [FIELD_W-1:0]  rd_tag;
  logic                wr_en;
  logic [FIELD_W-1:0]  wr_tag;
  logic                app_full;
  logic                app_order;

  logic [ROW_BITS-1:0] row;
  logic                hit;
  logic                counts;
  logic                drop;
  logic [BW-1:0]       kept_inc;
  logic [BW-1:0]       offset_inc;
  logic                batch_close;

  sdl_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .req_type       (in_req_type),
    .first_of_batch (in_first_of_batch),
    .search_done    (search_done),
    .ctl            (ctl)
  );

  assign mid         = lo_r + ((hi_r - lo_r) >> 1);
  assign search_done = (lo_r >= hi_r);

  always_comb begin
    if (ctl.in_srch) begin
      rd_addr = search_done ? lo_r[AW-1:0] : mid[AW-1:0];
    end else begin
      rd_addr = ptr_r[AW-1:0];
    end
  end

  assign app_full  = (count_r == CW'(LIST_DEPTH));
  assign app_order = (count_r != '0) && (in_row_r <= last_row_r);
  assign wr_en     = ctl.run_cmd && (req_r == REQ_APPEND) && !app_full && !app_order;
  assign wr_tag    = in_has_r ? in_snap_r : '0;

  sdl_ram #(.WIDTH(ROW_BITS), .DEPTH(LIST_DEPTH)) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (in_row_r),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  sdl_ram #(.WIDTH(FIELD_W), .DEPTH(LIST_DEPTH)) u_tag_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_tag),
    .raddr (rd_addr),
    .rdata (rd_tag)
  );

  assign row         = batch_start_r + ROW_BITS'(offset_r);
  assign hit         = (ptr_r < count_r) && (rd_row == row);
  assign counts      = !(snap_en_r && tags_r) || (rd_tag <= snap_limit_r);
  assign drop        = (hit && counts) ||
                       (max_rows_en_r && (CMP_W'(row) >= CMP_W'(max_rows_r)));
  assign kept_inc    = kept_r + BW'(!drop);
  assign offset_inc  = offset_r + BW'(1);
  assign batch_close = in_last_r || (offset_inc >= BW'(BATCH_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rows_en_r <= 1'b0;
      max_rows_r    <= '0;
      snap_en_r     <= 1'b0;
      snap_limit_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_ROWS_EN: max_rows_en_r <= cfg_wdata[0];
        CFG_MAX_ROWS:    max_rows_r    <= cfg_wdata;
        CFG_SNAP_EN:     snap_en_r     <= cfg_wdata[0];
        CFG_SNAP_LIMIT:  snap_limit_r  <= cfg_wdata;
        default:         max_rows_en_r <= max_rows_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_r     <= in_req_type;
      in_row_r  <= ROW_BITS'(in_row_id);
      in_snap_r <= in_snapshot_id;
      in_has_r  <= in_has_snapshot;
      in_last_r <= in_last_of_batch;
    end
    if (wr_en) begin
      last_row_r <= in_row_r;
    end
    if (ctl.accept && in_req_type == REQ_FILTER && in_first_of_batch) begin
      lo_r <= '0;
      hi_r <= count_r;
    end else if (ctl.srch_cmp) begin
      if (rd_row < batch_start_r) begin
        lo_r <= mid + CW'(1);
      end else begin
        hi_r <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      tags_r        <= 1'b0;
      batch_start_r <= '0;
      offset_r      <= '0;
      kept_r        <= '0;
      ptr_r         <= '0;
    end else begin
      if (ctl.run_cmd && req_r == REQ_CLEAR) begin
        count_r <= '0;
        tags_r  <= 1'b0;
        ptr_r   <= '0;
      end
      if (wr_en) begin
        count_r <= count_r + CW'(1);
        tags_r  <= tags_r | in_has_r;
      end
      if (ctl.accept && in_req_type == REQ_FILTER && in_first_of_batch) begin
        batch_start_r <= ROW_BITS'(in_row_id);
        offset_r      <= '0;
        kept_r        <= '0;
      end
      if (ctl.srch_end) begin
        ptr_r <= lo_r;
      end
      if (ctl.eval) begin
        ptr_r <= ptr_r + CW'(hit);
        if (batch_close) begin
          batch_start_r <= row + ROW_BITS'(1);
          offset_r      <= '0;
          kept_r        <= '0;
        end else begin
          offset_r <= offset_inc;
          kept_r   <= kept_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.run_cmd || ctl.eval;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.run_cmd) begin
      if (req_r == REQ_APPEND && app_full) begin
        out_status_r <= ST_FULL;
      end else if (req_r == REQ_APPEND && app_order) begin
        out_status_r <= ST_ORDER;
      end else begin
        out_status_r <= ST_OK;
      end
      out_keep_r   <= 1'b0;
      out_pos_r    <= '0;
      out_offset_r <= '0;
      out_total_r  <= '0;
      out_last_r   <= 1'b0;
    end else if (ctl.eval) begin
      out_status_r <= ST_OK;
      out_keep_r   <= !drop;
      out_pos_r    <= POS_W'(kept_r);
      out_offset_r <= POS_W'(offset_r);
      out_total_r  <= TOTAL_W'(kept_inc);
      out_last_r   <= in_last_r;
    end
  end

  assign busy              = ctl.busy;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_keep          = out_keep_r;
  assign out_kept_position = out_pos_r;
  assign out_row_offset    = out_offset_r;
  assign out_kept_total    = out_total_r;
  assign out_last          = out_last_r;

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(ctl.run_cmd || ctl.eval))
    else $error("result strobe without a finished word");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.in_srch || ctl.srch_cmp) |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search window out of range");

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= offset_r)
    else $error("kept count exceeds batch offset");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.in_srch || ctl.srch_cmp || ctl.eval) |-> !wr_en)
    else $error("list write during a row lookup");

endmodule
`default_nettype wire

@@ dv/sorted_delete_list_row_filter_test.sv @@
// Self-checking testbench for the sorted delete-list row filter: directed and random words.
module sorted_delete_list_row_filter_test;
  import sdl_pkg::*;

  localparam int LIST_DEPTH  = 4096;
  localparam int BATCH_ROWS  = 2048;
  localparam int FILL_ROWS   = 320;
  localparam int LONG_BATCH  = 200;
  localparam int MIXED_WORDS = 950;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [FIELD_W-1:0] ROW_MAX = '1;

  typedef struct packed {
    req_t               rq;
    logic [FIELD_W-1:0] rid;
    logic [FIELD_W-1:0] sid;
    logic               hs;
    logic               fb;
    logic               lb;
  } word_t;

  typedef struct packed {
    status_t            status;
    logic               keep;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   offs;
    logic [TOTAL_W-1:0] total;
    logic               eob;
  } word_result_t;

  typedef struct {
    word_t        w;
    bit           typed;
    word_result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [FIELD_W-1:0] in_row_id = '0;
  logic [FIELD_W-1:0] in_snapshot_id = '0;
  logic in_has_snapshot = 1'b0;
  logic in_first_of_batch = 1'b0;
  logic in_last_of_batch = 1'b0;
  logic out_valid;
  logic [STAT_W-1:0] out_status;
  logic out_keep;
  logic [POS_W-1:0] out_kept_position;
  logic [POS_W-1:0] out_row_offset;
  logic [TOTAL_W-1:0] out_kept_total;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [FIELD_W-1:0] cfg_wdata = '0;

  sorted_delete_list_row_filter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_row_id(in_row_id), .in_snapshot_id(in_snapshot_id),
    .in_has_snapshot(in_has_snapshot), .in_first_of_batch(in_first_of_batch),
    .in_last_of_batch(in_last_of_batch),
    .out_valid(out_valid), .out_status(out_status), .out_keep(out_keep),
    .out_kept_position(out_kept_position), .out_row_offset(out_row_offset),
    .out_kept_total(out_kept_total), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block's list, batch state and registers.
  logic [FIELD_W-1:0] del_rows [LIST_DEPTH];
  logic [FIELD_W-1:0] del_tags [LIST_DEPTH];
  int unsigned n_entries = 0;
  logic tags_seen = 1'b0;
  logic [FIELD_W-1:0] base_row = '0;
  int unsigned row_offs = 0;
  int unsigned list_ptr = 0;
  int unsigned kept_cnt = 0;
  logic cf_max_en = 1'b0;
  logic [FIELD_W-1:0] cf_max = '0;
  logic cf_snap_en = 1'b0;
  logic [FIELD_W-1:0] cf_snap_lim = '0;

  word_result_t pending_words [$];
  dir_row_t dir_rows [$];
  bit burst = 1'b0;
  int n_words = 0;
  int n_rows = 0;
  int n_kept_rows = 0;
  int n_rejected = 0;
  int n_settings = 0;
  int n_bad = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [FIELD_W-1:0] rand48();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[FIELD_W-1:0];
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic word_t mk(req_t rq, logic [FIELD_W-1:0] rid, logic [FIELD_W-1:0] sid,
                               logic hs, logic fb, logic lb);
    word_t w;
    w.rq = rq;
    w.rid = rid;
    w.sid = sid;
    w.hs = hs;
    w.fb = fb;
    w.lb = lb;
    return w;
  endfunction

  function automatic word_result_t outc(status_t s, logic k, int p, int o, int t, logic l);
    word_result_t r;
    r.status = s;
    r.keep = k;
    r.pos = POS_W'(p);
    r.offs = POS_W'(o);
    r.total = TOTAL_W'(t);
    r.eob = l;
    return r;
  endfunction

  function automatic void add_dir(word_t w, bit typed, word_result_t want);
    dir_row_t d;
    d.w = w;
    d.typed = typed;
    d.want = want;
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  function automatic word_result_t predict_word(word_t w);
    word_result_t r;
    logic [FIELD_W-1:0] row;
    logic drop;
    logic counts;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    r = '0;
    case (w.rq)
      REQ_CLEAR: begin
        n_entries = 0;
        tags_seen = 1'b0;
        list_ptr = 0;
      end
      REQ_APPEND: begin
        if (n_entries >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (n_entries > 0 && w.rid <= del_rows[n_entries-1]) begin
          r.status = ST_ORDER;
        end else begin
          del_rows[n_entries] = w.rid;
          del_tags[n_entries] = w.hs ? w.sid : '0;
          if (w.hs) tags_seen = 1'b1;
          n_entries++;
        end
      end
      REQ_FILTER: begin
        if (w.fb) begin
          base_row = w.rid;
          row_offs = 0;
          kept_cnt = 0;
          lo = 0;
          hi = n_entries;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (del_rows[mid] < w.rid) lo = mid + 1;
            else hi = mid;
          end
          list_ptr = lo;
        end
        row = base_row + FIELD_W'(row_offs);
        drop = 1'b0;
        if (list_ptr < n_entries && del_rows[list_ptr] == row) begin
          counts = 1'b1;
          if (cf_snap_en && tags_seen) counts = (del_tags[list_ptr] <= cf_snap_lim);
          list_ptr++;
          if (counts) drop = 1'b1;
        end
        if (cf_max_en && row >= cf_max) drop = 1'b1;
        r.pos = POS_W'(kept_cnt);
        if (!drop) kept_cnt++;
        r.keep = !drop;
        r.offs = POS_W'(row_offs);
        r.total = TOTAL_W'(kept_cnt);
        r.eob = w.lb;
        row_offs++;
        if (w.lb || row_offs >= BATCH_ROWS) begin
          base_row = row + 1'b1;
          row_offs = 0;
          kept_cnt = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input word_t w, input bit typed, input word_result_t want);
    int gap;
    int r;
    word_result_t predicted;
    r = $urandom_range(0, 99);
    if (burst || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= w.rq;
    in_row_id <= w.rid;
    in_snapshot_id <= w.sid;
    in_has_snapshot <= w.hs;
    in_first_of_batch <= w.fb;
    in_last_of_batch <= w.lb;
    do @(posedge clk); while (busy);
    predicted = predict_word(w);
    pending_words.insert(pending_words.size(), typed ? want : predicted);
    n_words++;
    if (w.rq == REQ_FILTER) begin
      n_rows++;
      if (predicted.keep) n_kept_rows++;
    end
    if (predicted.status != ST_OK) n_rejected++;
  endtask

  task automatic send_plain(input word_t w);
    send_word(w, 1'b0, '0);
  endtask

  task automatic drain_block();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic program_regs(input logic mr_en, input logic [FIELD_W-1:0] mr,
                              input logic sn_en, input logic [FIELD_W-1:0] lim);
    logic [FIELD_W-1:0] junk;
    junk = rand48();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_MAX_ROWS_EN;
    cfg_wdata <= {junk[FIELD_W-1:1], mr_en};
    @(posedge clk);
    cfg_addr <= CFG_MAX_ROWS;
    cfg_wdata <= mr;
    @(posedge clk);
    junk = rand48();
    cfg_addr <= CFG_SNAP_EN;
    cfg_wdata <= {junk[FIELD_W-1:1], sn_en};
    @(posedge clk);
    cfg_addr <= CFG_SNAP_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    cf_max_en = mr_en;
    cf_max = mr;
    cf_snap_en = sn_en;
    cf_snap_lim = lim;
    n_settings++;
  endtask

  // Loads a long list, then runs one long batch and several short batches over it.
  task automatic run_fill_phase();
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] prev;
    int k;
    int len;
    drain_block();
    burst = 1'b0;
    program_regs(1'b0, ROW_MAX, 1'b1, FIELD_W'(7));
    send_plain(mk(REQ_CLEAR, rand48(), rand48(), coin(), coin(), coin()));
    row = FIELD_W'(5000 + $urandom_range(0, 999));
    prev = row;
    for (k = 0; k < FILL_ROWS; k++) begin
      if (k % 512 == 100)
        send_plain(mk(REQ_APPEND, prev - FIELD_W'($urandom_range(0, 2)), rand48(), coin(),
                      coin(), coin()));
      send_plain(mk(REQ_APPEND, row, FIELD_W'($urandom_range(0, 15)),
                    $urandom_range(0, 7) != 0, coin(), coin()));
      prev = row;
      row = row + FIELD_W'($urandom_range(1, 3));
    end
    send_plain(mk(REQ_APPEND, row, rand48(), 1'b1, coin(), coin()));
    send_plain(mk(REQ_APPEND, '0, rand48(), 1'b0, coin(), coin()));
    for (k = 0; k < LONG_BATCH; k++)
      send_plain(mk(REQ_FILTER, (k == 0) ? '0 : rand48(), rand48(), coin(), k == 0,
                    k == LONG_BATCH - 1));
    repeat (10) begin
      row = FIELD_W'(4990 + $urandom_range(0, 1700));
      len = $urandom_range(1, 50);
      for (k = 0; k < len; k++)
        send_plain(mk(REQ_FILTER, (k == 0) ? row : rand48(), rand48(), coin(), k == 0,
                      k == len - 1));
    end
  endtask

  task automatic send_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) send_plain(mk(REQ_NONE, rand48(), rand48(), coin(), coin(), coin()));
    else if (r < 9) send_plain(mk(REQ_APPEND, rand48(), rand48(), coin(), coin(), coin()));
    else send_plain(mk(REQ_CLEAR, rand48(), rand48(), coin(), coin(), coin()));
  endtask

  // One register setting, a short list near a chosen base and a few batches over it.
  task automatic run_mixed_phase();
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] mr;
    logic [FIELD_W-1:0] lim;
    logic [FIELD_W-1:0] sid;
    logic untagged;
    logic fresh;
    int n_list;
    int span;
    int len;
    int k;
    drain_block();
    burst = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = ROW_MAX - FIELD_W'($urandom_range(0, 300));
      default: base = rand48();
    endcase
    n_list = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
    span = n_list * 3 + 8;
    case ($urandom_range(0, 3))
      0: mr = '0;
      1: mr = ROW_MAX;
      default: mr = base + FIELD_W'($urandom_range(0, span));
    endcase
    case ($urandom_range(0, 3))
      0: lim = '0;
      1: lim = ROW_MAX;
      default: lim = FIELD_W'($urandom_range(0, 15));
    endcase
    program_regs(coin(), mr, coin(), lim);
    untagged = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) != 0)
      send_plain(mk(REQ_CLEAR, rand48(), rand48(), coin(), coin(), coin()));
    row = base;
    for (k = 0; k < n_list; k++) begin
      sid = ($urandom_range(0, 7) == 0) ? rand48() : FIELD_W'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        send_plain(mk(REQ_APPEND, row - FIELD_W'($urandom_range(1, 4)), sid, coin(), coin(),
                      coin()));
      end else begin
        send_plain(mk(REQ_APPEND, row, sid, !untagged && $urandom_range(0, 3) != 0, coin(),
                      coin()));
        row = row + FIELD_W'($urandom_range(1, 3));
      end
    end
    repeat ($urandom_range(1, 6)) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 200) : $urandom_range(1, 30);
      row = base - FIELD_W'(3) + FIELD_W'($urandom_range(0, span));
      fresh = ($urandom_range(0, 7) != 0);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 24) == 0) send_noise();
        send_plain(mk(REQ_FILTER, (k == 0 && fresh) ? row : rand48(), rand48(), coin(),
                      k == 0 && fresh, k == len - 1));
      end
    end
  endtask

  always @(posedge clk) begin
    word_result_t want;
    word_result_t seen;
    if (rst_n && out_valid) begin
      seen.status = status_t'(out_status);
      seen.keep = out_keep;
      seen.pos = out_kept_position;
      seen.offs = out_row_offset;
      seen.total = out_kept_total;
      seen.eob = out_last;
      if (pending_words.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("Result word with nothing expected: %p", seen);
      end else begin
        want = pending_words.pop_front();
        if (seen !== want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("Mismatch: expected st=%0d keep=%0d pos=%0d off=%0d tot=%0d last=%0d,",
                     want.status, want.keep, want.pos, want.offs, want.total, want.eob);
            $display("          got      st=%0d keep=%0d pos=%0d off=%0d tot=%0d last=%0d",
                     seen.status, seen.keep, seen.pos, seen.offs, seen.total, seen.eob);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles,
               pending_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int mixed_from;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_dir(mk(REQ_NONE, ROW_MAX, ROW_MAX, 1, 1, 1), 1, outc(ST_OK, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_FILTER, '0, '0, 0, 1, 0), 1, outc(ST_OK, 1, 0, 0, 1, 0));
    add_dir(mk(REQ_FILTER, ROW_MAX, ROW_MAX, 1, 0, 1), 1, outc(ST_OK, 1, 1, 1, 2, 1));
    add_dir(mk(REQ_APPEND, 48'd5, ROW_MAX, 1, 1, 1), 1, outc(ST_OK, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_APPEND, 48'd5, '0, 0, 0, 0), 1, outc(ST_ORDER, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_APPEND, 48'd3, '0, 1, 0, 0), 1, outc(ST_ORDER, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_APPEND, ROW_MAX, ROW_MAX, 0, 0, 0), 1, outc(ST_OK, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_APPEND, ROW_MAX, '0, 1, 1, 1), 1, outc(ST_ORDER, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_FILTER, 48'd4, '0, 0, 1, 0), 1, outc(ST_OK, 1, 0, 0, 1, 0));
    add_dir(mk(REQ_FILTER, '0, '0, 0, 0, 0), 1, outc(ST_OK, 0, 1, 1, 1, 0));
    add_dir(mk(REQ_FILTER, '0, '0, 0, 0, 1), 1, outc(ST_OK, 1, 1, 2, 2, 1));
    add_dir(mk(REQ_FILTER, ROW_MAX - 1'b1, '0, 0, 1, 0), 1, outc(ST_OK, 1, 0, 0, 1, 0));
    add_dir(mk(REQ_FILTER, '0, '0, 0, 0, 0), 1, outc(ST_OK, 0, 1, 1, 1, 0));
    add_dir(mk(REQ_FILTER, '0, '0, 0, 0, 1), 1, outc(ST_OK, 1, 1, 2, 2, 1));
    add_dir(mk(REQ_CLEAR, ROW_MAX, ROW_MAX, 1, 1, 1), 1, outc(ST_OK, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_APPEND, '0, '0, 0, 0, 0), 1, outc(ST_OK, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_FILTER, '0, '0, 0, 1, 1), 1, outc(ST_OK, 0, 0, 0, 0, 1));
    add_dir(mk(REQ_NONE, '0, '0, 0, 0, 0), 1, outc(ST_OK, 0, 0, 0, 0, 0));
    add_dir(mk(REQ_APPEND, 48'h8000_0000_0000, ROW_MAX, 1, 0, 0), 0, '0);
    add_dir(mk(REQ_FILTER, 48'h7FFF_FFFF_FFFF, '0, 0, 1, 0), 0, '0);
    add_dir(mk(REQ_FILTER, '0, '0, 0, 0, 1), 0, '0);
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

    run_fill_phase();
    mixed_from = n_words;
    while (n_words - mixed_from < MIXED_WORDS) run_mixed_phase();
    drain_block();

    $display("Ran %0d words under %0d register settings, including a long list.",
             n_words, n_settings);
    $display("%0d filter rows (%0d kept), %0d appends rejected, %0d bad result words.",
             n_rows, n_kept_rows, n_rejected, n_bad);
    if (n_bad == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/sdl_pkg.sv
hdl/sdl_ram.sv
hdl/sdl_ctrl.sv
hdl/sorted_delete_list_row_filter.sv
dv/sorted_delete_list_row_filter_test.sv
